FILE: rtl/pl2sw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pl2sw_pkg;

    localparam int US_W        = 32;
    localparam int RATE_W      = 27;
    localparam int PROD_W      = US_W + RATE_W;
    localparam int TICK_W      = 40;
    localparam int DUR_W       = 15;
    localparam int WORD_W      = 32;
    localparam int MUL_W       = 32;
    localparam int PRE_SHIFT   = 6;
    localparam int X_W         = PROD_W - PRE_SHIFT;
    localparam int RECIP_W     = 54;
    localparam int RECIP_SHIFT = 67;
    localparam int ACC_W       = X_W + RECIP_W;

    localparam logic [DUR_W-1:0]   CHUNK_MAX  = 15'h7FFF;
    localparam logic [19:0]        US_PER_SEC = 20'd1000000;
    localparam logic [RATE_W-1:0]  RATE_RESET = 27'd1000000;
    // Rounded-up 2^67 / 15625; exact floor division for every 53-bit dividend.
    localparam logic [RECIP_W-1:0] RECIP      = 54'd9444732965739291;

    typedef logic [TICK_W-1:0] tick_t;
    typedef logic [DUR_W-1:0]  dur_t;

endpackage

`default_nettype wire

FILE: rtl/pulse_list_to_symbol_words.sv
`timescale 1ns / 1ps
`default_nettype none

// Pulse list to symbol word encoder. Each request carries a pulse length in
// microseconds; it is scaled to ticks of tick_rate_hz (floor of us*rate/1e6,
// at least one tick), cut into segments of at most 32767 ticks, and the
// segments are packed two to a 32-bit word (duration0 [14:0], level0 [15],
// duration1 [30:16], level1 [31]). The last request of a list flushes an odd
// segment with a zero partner and then emits a zero end-marker word. One
// shared 32x32 multiplier does all the arithmetic: it forms us*rate on the
// accepting cycle, then the division by 1e6 sums four reciprocal partial
// products. After that the block cuts the segments off one at a time, closes
// the segment loop, and on the last request adds a flush word for a pending
// odd segment and the marker word; every word also waits for the output
// register to free up. in_ready is high only while the sequencer is idle,
// and the next request can be taken while the previous word still waits on
// the output. Segments beyond MAX_SEGMENTS per list are dropped.
module pulse_list_to_symbol_words #(
    parameter int MAX_SEGMENTS = 94
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   cfg_valid,
    output logic                                  cfg_ready,
    input  wire  [pl2sw_pkg::RATE_W-1:0]          tick_rate_hz,
    input  wire                                   in_valid,
    output logic                                  in_ready,
    input  wire  [pl2sw_pkg::US_W-1:0]            duration_us,
    input  wire                                   first_level,
    input  wire                                   last_item,
    output logic                                  out_valid,
    input  wire                                   out_ready,
    output logic [pl2sw_pkg::WORD_W-1:0]          symbol_word,
    output logic                                  end_marker,
    output logic                                  last_of_item
);
    import pl2sw_pkg::*;

    localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_SEG   = 3'd2;
    localparam logic [2:0] S_FLUSH = 3'd3;
    localparam logic [2:0] S_MARK  = 3'd4;

    localparam logic [1:0] MUL_LAST = 2'd3;

    logic [2:0]            state_reg, state_next;
    logic [RATE_W-1:0]     rate_reg;
    logic [PROD_W-1:0]     prod_reg, prod_next;
    logic [ACC_W-1:0]      acc_reg, acc_next;
    logic [1:0]            mul_step_reg, mul_step_next;
    tick_t                 ticks_reg, ticks_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  level_reg, level_next;
    logic                  list_start_reg, list_start_next;
    logic                  last_reg, last_next;
    dur_t                  pend_dur_reg, pend_dur_next;
    logic                  pend_lvl_reg, pend_lvl_next;
    logic                  pend_valid_reg, pend_valid_next;
    logic                  out_valid_reg, out_valid_next;
    logic [WORD_W-1:0]     word_reg, word_next;
    logic                  marker_reg, marker_next;
    logic                  last_out_reg, last_out_next;

    logic                  in_fire;
    logic                  slot_free;
    logic [MUL_W-1:0]      mul_a;
    logic [MUL_W-1:0]      mul_b;
    logic [2*MUL_W-1:0]    mul_p;
    logic [ACC_W-1:0]      pp_term;
    logic [ACC_W-1:0]      acc_sum;
    tick_t                 quotient;
    dur_t                  chunk;
    tick_t                 ticks_after;
    logic [CNT_W+1:0]      cnt_plus3;
    logic                  more_words;
    logic                  seg_done;

    assign cfg_ready    = 1'b1;
    assign in_ready     = (state_reg == S_IDLE);
    assign in_fire      = in_valid && in_ready;
    assign out_valid    = out_valid_reg;
    assign symbol_word  = word_reg;
    assign end_marker   = marker_reg;
    assign last_of_item = last_out_reg;
    assign slot_free    = !out_valid_reg || out_ready;

    // The quotient by 1e6 is (P >> 6) times the reciprocal of 15625, shifted
    // down by 67. The four partial products of the 32-bit halves are summed
    // one per cycle.
    always_comb
    begin
        if (state_reg == S_IDLE)
        begin
            mul_a = duration_us;
            mul_b = MUL_W'(rate_reg);
        end
        else
        begin
            mul_a = mul_step_reg[1] ? MUL_W'(prod_reg[PROD_W-1:PRE_SHIFT+MUL_W])
                                    : prod_reg[PRE_SHIFT+MUL_W-1:PRE_SHIFT];
            mul_b = mul_step_reg[0] ? MUL_W'(RECIP[RECIP_W-1:MUL_W]) : RECIP[MUL_W-1:0];
        end
    end

    assign mul_p = (2*MUL_W)'(mul_a) * (2*MUL_W)'(mul_b);

    always_comb
    begin
        unique case (mul_step_reg)
            2'd0:       pp_term = ACC_W'(mul_p);
            2'd1, 2'd2: pp_term = ACC_W'(mul_p) << MUL_W;
            2'd3:       pp_term = ACC_W'(mul_p) << (2 * MUL_W);
        endcase
    end

    assign acc_sum  = acc_reg + pp_term;
    assign quotient = acc_sum[ACC_W-1:RECIP_SHIFT];

    assign chunk       = (ticks_reg > TICK_W'(CHUNK_MAX)) ? CHUNK_MAX : ticks_reg[DUR_W-1:0];
    assign ticks_after = ticks_reg - TICK_W'(chunk);
    assign cnt_plus3   = (CNT_W+2)'(cnt_reg) + (CNT_W+2)'(3);
    // Another pair word needs two more segments within the cap.
    assign more_words  = last_reg ||
                         ((ticks_after > TICK_W'(CHUNK_MAX)) &&
                          (cnt_plus3 <= (CNT_W+2)'(MAX_SEGMENTS)));
    assign seg_done    = (ticks_reg == '0) || (cnt_reg >= CNT_W'(MAX_SEGMENTS));

    always_comb
    begin
        state_next      = state_reg;
        prod_next       = prod_reg;
        acc_next        = acc_reg;
        mul_step_next   = mul_step_reg;
        ticks_next      = ticks_reg;
        cnt_next        = cnt_reg;
        level_next      = level_reg;
        list_start_next = list_start_reg;
        last_next       = last_reg;
        pend_dur_next   = pend_dur_reg;
        pend_lvl_next   = pend_lvl_reg;
        pend_valid_next = pend_valid_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        word_next       = word_reg;
        marker_next     = marker_reg;
        last_out_next   = last_out_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    prod_next     = mul_p[PROD_W-1:0];
                    acc_next      = '0;
                    mul_step_next = '0;
                    last_next     = last_item;
                    if (list_start_reg)
                    begin
                        level_next      = first_level;
                        list_start_next = 1'b0;
                    end
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                acc_next      = acc_sum;
                mul_step_next = mul_step_reg + 2'd1;
                if (mul_step_reg == MUL_LAST)
                begin
                    ticks_next = (quotient == '0) ? TICK_W'(1) : quotient;
                    state_next = S_SEG;
                end
            end
            S_SEG:
            begin
                if (seg_done)
                begin
                    level_next = !level_reg;
                    ticks_next = '0;
                    if (!last_reg)
                        state_next = S_IDLE;
                    else if (pend_valid_reg)
                        state_next = S_FLUSH;
                    else
                        state_next = S_MARK;
                end
                else if (pend_valid_reg)
                begin
                    if (slot_free)
                    begin
                        out_valid_next  = 1'b1;
                        word_next       = {level_reg, chunk, pend_lvl_reg, pend_dur_reg};
                        marker_next     = 1'b0;
                        last_out_next   = !more_words;
                        pend_valid_next = 1'b0;
                        ticks_next      = ticks_after;
                        cnt_next        = cnt_reg + CNT_W'(1);
                    end
                end
                else
                begin
                    pend_dur_next   = chunk;
                    pend_lvl_next   = level_reg;
                    pend_valid_next = 1'b1;
                    ticks_next      = ticks_after;
                    cnt_next        = cnt_reg + CNT_W'(1);
                end
            end
            S_FLUSH:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    word_next       = {1'b0, {DUR_W{1'b0}}, pend_lvl_reg, pend_dur_reg};
                    marker_next     = 1'b0;
                    last_out_next   = 1'b0;
                    pend_valid_next = 1'b0;
                    state_next      = S_MARK;
                end
            end
            S_MARK:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    word_next       = '0;
                    marker_next     = 1'b1;
                    last_out_next   = 1'b1;
                    list_start_next = 1'b1;
                    pend_valid_next = 1'b0;
                    pend_dur_next   = '0;
                    pend_lvl_next   = 1'b0;
                    cnt_next        = '0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            rate_reg       <= RATE_RESET;
            ticks_reg      <= '0;
            cnt_reg        <= '0;
            level_reg      <= 1'b0;
            list_start_reg <= 1'b1;
            last_reg       <= 1'b0;
            pend_dur_reg   <= '0;
            pend_lvl_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            mul_step_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            if (cfg_valid)
                rate_reg <= tick_rate_hz;
            ticks_reg      <= ticks_next;
            cnt_reg        <= cnt_next;
            level_reg      <= level_next;
            list_start_reg <= list_start_next;
            last_reg       <= last_next;
            pend_dur_reg   <= pend_dur_next;
            pend_lvl_reg   <= pend_lvl_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            mul_step_reg   <= mul_step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg     <= prod_next;
        acc_reg      <= acc_next;
        word_reg     <= word_next;
        marker_reg   <= marker_next;
        last_out_reg <= last_out_next;
    end

endmodule

`default_nettype wire

FILE: rtl/pl2sw_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module pl2sw_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        in_valid,
    input wire        in_ready,
    input wire        out_valid,
    input wire        out_ready,
    input wire [31:0] symbol_word,
    input wire        end_marker,
    input wire        last_of_item
);

    // A waiting word must not change under a stalled output.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(symbol_word)
                                    && $stable(end_marker) && $stable(last_of_item))
        else $error("output word changed while stalled");

    // The end marker is all zeros and always closes its request.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && end_marker |-> symbol_word == 32'd0 && last_of_item)
        else $error("end marker word malformed");

    // Every segment lasts at least one tick, so only the marker is zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && symbol_word == 32'd0 |-> end_marker)
        else $error("zero word without end marker");

    // After taking a request the block is busy with the division.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while previous one in progress");

endmodule

bind pulse_list_to_symbol_words pl2sw_checker u_pl2sw_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .symbol_word  (symbol_word),
    .end_marker   (end_marker),
    .last_of_item (last_of_item)
);

`default_nettype wire
